// ===== rtl/soft_timer_bank_macros.svh =====
// Assertion helpers for the timer bank; each expects clk and arst_n in scope.
`ifndef SOFT_TIMER_BANK_MACROS_SVH
`define SOFT_TIMER_BANK_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define STB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/stb_pkg.sv =====
`default_nettype none

package stb_pkg;

	localparam int FUNC_W   = 3;
	localparam int ID_W     = 5;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 3'd0,
		FN_START  = 3'd1,
		FN_PAUSE  = 3'd2,
		FN_RESUME = 3'd3,
		FN_UPDATE = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD_WB,
		S_UPD,
		S_EMIT
	} state_t;

	// One timer entry as held in the timer memory.
	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] period;
		logic              running;
		logic              notify;
	} entry_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] assigned_id;
		logic            expired;
		logic [ID_W-1:0] expired_id;
		logic            last;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/stb_if.sv =====
`default_nettype none

interface stb_cmd_if import stb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ID_W-1:0]   timer_id;
	logic [TIME_W-1:0] period;
	logic              notify;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, func, timer_id, period, notify, now_ms, input ready);
	modport sink (input valid, func, timer_id, period, notify, now_ms, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     assigned_id;
	logic                expired;
	logic [ID_W-1:0]     expired_id;
	logic                last;

	modport source (output valid, status, assigned_id, expired, expired_id, last,
		input ready);
	modport sink (input valid, status, assigned_id, expired, expired_id, last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/stb_ram.sv =====
`default_nettype none

module stb_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/stb_ctrl.sv =====
`default_nettype none

module stb_ctrl import stb_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stb_cmd_if.sink   cmd,
	input  wire logic slot_free,
	output logic      res_push,
	output result_t   res
);

	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int XW = (CW > ID_W) ? CW : ID_W;
	localparam int EW = $bits(entry_t);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] delta_q;
	func_t             func_q;
	logic [IW-1:0]     cmd_idx_q;
	logic [CW-1:0]     rd_idx_q;
	logic              rd_valid_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              hold_valid_q;
	logic [ID_W-1:0]   hold_id_q;
	result_t           res_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_e;

	stb_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_e = ram_rdata;

	// Command decode
	logic          accept, is_add, is_cmd, is_upd, full, id_bad;
	logic [XW-1:0] id_x, cnt_x, id_m1, aid_x, eid_x;
	logic [IW-1:0] cmd_idx;
	result_t       res_acc;

	assign accept = cmd.valid && cmd.ready;
	assign is_add = cmd.func == FN_ADD;
	assign is_cmd = cmd.func == FN_START || cmd.func == FN_PAUSE || cmd.func == FN_RESUME;
	assign is_upd = cmd.func == FN_UPDATE;
	assign full   = count_q == CW'(NUM_TIMERS);
	assign id_x   = XW'(cmd.timer_id);
	assign cnt_x  = XW'(count_q);
	assign id_bad = id_x == '0 || id_x > cnt_x;
	assign id_m1  = id_x - XW'(1);
	assign cmd_idx = id_m1[IW-1:0];
	assign aid_x  = cnt_x + XW'(1);
	assign eid_x  = XW'(rd_idx_s1) + XW'(1);

	always_comb begin
		res_acc = '{status: ST_OK, assigned_id: '0, expired: 1'b0, expired_id: '0,
			last: 1'b1};
		if (is_add) begin
			if (full) begin
				res_acc.status = ST_FULL;
			end else begin
				res_acc.assigned_id = aid_x[ID_W-1:0];
			end
		end else if (is_cmd && id_bad) begin
			res_acc.status = ST_BAD_ID;
		end
	end

	// Update walk: saturating advance of the entry read last cycle
	logic [TIME_W:0]   sum_w;
	logic [TIME_W-1:0] sat;
	logic              hit, proc, report, stall, more, upd_done;

	assign sum_w    = {1'b0, rd_e.elapsed} + {1'b0, delta_q};
	assign sat      = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];
	assign hit      = sat >= rd_e.period;
	assign proc     = state_q == S_UPD && rd_valid_s1 && rd_e.running;
	assign report   = proc && hit && rd_e.notify;
	// a second expiry needs the held word out first
	assign stall    = report && hold_valid_q && !slot_free;
	assign more     = rd_idx_q < count_q;
	assign upd_done = state_q == S_UPD && !stall && !rd_valid_s1 && !more;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_upd) begin
						state_d = S_UPD;
					end else if (is_cmd && !id_bad) begin
						state_d = S_CMD_WB;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_CMD_WB: state_d = S_EMIT;
			S_UPD: begin
				if (upd_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		res_push  = 1'b0;
		res       = res_q;
		ram_we    = 1'b0;
		ram_waddr = cmd_idx_q;
		ram_wdata = rd_e;
		ram_raddr = cmd_idx;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (accept && is_add && !full) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IW-1:0];
					ram_wdata = '{elapsed: '0, period: cmd.period, running: 1'b0,
						notify: cmd.notify};
				end
			end
			S_CMD_WB: begin
				ram_we = 1'b1;
				case (func_q)
					FN_START: begin
						ram_wdata.elapsed = '0;
						ram_wdata.running = 1'b1;
					end
					FN_PAUSE: ram_wdata.running = 1'b0;
					default:  ram_wdata.running = 1'b1;
				endcase
			end
			S_UPD: begin
				// on a stall, read the held entry again so its data stays
				ram_raddr = stall ? rd_idx_s1 : rd_idx_q[IW-1:0];
				if (proc && !stall) begin
					ram_we            = 1'b1;
					ram_waddr         = rd_idx_s1;
					ram_wdata.elapsed = hit ? '0 : sat;
				end
				if (report && hold_valid_q && !stall) begin
					res_push = 1'b1;
					res      = '{status: ST_OK, assigned_id: '0, expired: 1'b1,
						expired_id: hold_id_q, last: 1'b0};
				end
			end
			S_EMIT: res_push = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			last_time_q  <= '0;
			rd_idx_q     <= '0;
			rd_valid_s1  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_add && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (accept && is_upd) begin
				last_time_q  <= cmd.now_ms;
				rd_idx_q     <= '0;
				rd_valid_s1  <= 1'b0;
				hold_valid_q <= 1'b0;
			end
			if (state_q == S_UPD && !stall) begin
				if (report) begin
					hold_valid_q <= 1'b1;
				end
				rd_valid_s1 <= more;
				if (more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func_t'(cmd.func);
			cmd_idx_q <= cmd_idx;
			res_q     <= res_acc;
			if (is_upd) begin
				delta_q <= cmd.now_ms - last_time_q;
			end
		end
		if (state_q == S_UPD && !stall) begin
			rd_idx_s1 <= rd_idx_q[IW-1:0];
			if (report) begin
				hold_id_q <= eid_x[ID_W-1:0];
			end
		end
		if (upd_done && hold_valid_q) begin
			res_q <= '{status: ST_OK, assigned_id: '0, expired: 1'b1,
				expired_id: hold_id_q, last: 1'b1};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/soft_timer_bank.sv =====
// Add, bad id and unused codes: after acceptance, S_EMIT pushes the word into the output register.
// Start, pause, resume: one read-modify-write of the timer memory, written back in S_CMD_WB.
// Update: S_UPD walks the allocated timers, one memory entry per cycle while not stalled;
// each further expiry word waits for the output register to drain.
// Next word accepted once the final one is in the output register.
// Reset (arst_n low, asynchronous) clears the timer count, the time base and all control;
// the timer memory is not cleared, each entry being written by its add before any use.
`default_nettype none

`include "soft_timer_bank_macros.svh"

module soft_timer_bank import stb_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stb_cmd_if.sink   cmd,
	stb_rsp_if.source rsp
);

	logic    res_push;
	result_t res;
	logic    slot_free;
	logic    rsp_valid_q;
	result_t rsp_q;

	assign slot_free = !rsp_valid_q || rsp.ready;

	stb_ctrl #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.slot_free(slot_free),
		.res_push (res_push),
		.res      (res)
	);

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.assigned_id = rsp_q.assigned_id;
	assign rsp.expired     = rsp_q.expired;
	assign rsp.expired_id  = rsp_q.expired_id;
	assign rsp.last        = rsp_q.last;

	`STB_ASSERT_NOW(a_no_overwrite, res_push && rsp_valid_q, rsp.ready, "result word overwritten")
	`STB_ASSERT_NEXT(a_busy_mid_walk, res_push && !res.last, !cmd.ready, "input taken mid update")
	`STB_ASSERT_NOW(a_expiry_form, rsp.valid && rsp.expired, rsp.status == ST_OK && rsp.assigned_id == '0, "malformed expiry word")

endmodule

`default_nettype wire

// ===== sim/stb_checker.sv =====
module stb_checker import stb_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	stb_cmd_if   cmd,
	stb_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	int                n_alloc;
	logic [TIME_W-1:0] time_base;
	logic [TIME_W-1:0] tick_cnt [NUM_TIMERS];
	logic [TIME_W-1:0] span [NUM_TIMERS];
	logic              live [NUM_TIMERS];
	logic              report [NUM_TIMERS];
	result_t           due_words [$];

	// Apply one command word to the bank copy and queue the words it should produce.
	task automatic apply_timer_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] per, input logic ntf, input logic [TIME_W-1:0] now);
		result_t           word;
		result_t           held;
		bit                have_held;
		logic [TIME_W-1:0] delta;
		logic [TIME_W:0]   sum;
		word = '0;
		word.status = ST_OK;
		word.last = 1'b1;
		held = '0;
		have_held = 1'b0;
		case (f)
			FN_ADD: begin
				if (n_alloc >= NUM_TIMERS) begin
					word.status = ST_FULL;
				end else begin
					tick_cnt[n_alloc] = '0;
					span[n_alloc] = per;
					live[n_alloc] = 1'b0;
					report[n_alloc] = ntf;
					n_alloc++;
					word.assigned_id = ID_W'(n_alloc);
				end
			end
			FN_START, FN_PAUSE, FN_RESUME: begin
				if (id == 0 || id > n_alloc) begin
					word.status = ST_BAD_ID;
				end else if (f == FN_START) begin
					tick_cnt[id-1] = '0;
					live[id-1] = 1'b1;
				end else begin
					live[id-1] = (f == FN_RESUME);
				end
			end
			FN_UPDATE: begin
				delta = now - time_base;
				time_base = now;
				for (int i = 0; i < n_alloc; i++) begin
					if (!live[i])
						continue;
					// saturate rather than wrap, so a huge step still reaches the period
					sum = {1'b0, tick_cnt[i]} + {1'b0, delta};
					if (sum[TIME_W])
						sum = {1'b0, {TIME_W{1'b1}}};
					if (sum[TIME_W-1:0] >= span[i]) begin
						tick_cnt[i] = '0;
						if (report[i]) begin
							// hold each expiry back one step so the final one gets last
							if (have_held)
								due_words.push_back(held);
							held = '0;
							held.status = ST_OK;
							held.expired = 1'b1;
							held.expired_id = ID_W'(i + 1);
							have_held = 1'b1;
						end
					end else begin
						tick_cnt[i] = sum[TIME_W-1:0];
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					word = held;
				end
			end
			default: begin
			end
		endcase
		due_words.push_back(word);
	endtask

	task automatic check_field(input string tag, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			n_alloc = 0;
			time_base = '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				tick_cnt[i] = '0;
				span[i] = '0;
				live[i] = 1'b0;
				report[i] = 1'b0;
			end
			due_words.delete();
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual status %0d id %0d exp %0d/%0d last %0d",
						$time, rsp.status, rsp.assigned_id, rsp.expired, rsp.expired_id,
						rsp.last);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("assigned_id", want.assigned_id, rsp.assigned_id);
					check_field("expired", want.expired, rsp.expired);
					check_field("expired_id", want.expired_id, rsp.expired_id);
					check_field("last", want.last, rsp.last);
				end
			end
			if (cmd.valid && cmd.ready)
				apply_timer_cmd(cmd.func, cmd.timer_id, cmd.period, cmd.notify, cmd.now_ms);
		end
		outstanding = due_words.size();
	end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import stb_pkg::*;

	localparam int NUM_TIMERS = 16;
	localparam int HOLD_CYCLES = 300;
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	logic              clk;
	logic              arst_n = 1'b0;
	int                err_cnt;
	int                in_flight;
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;
	bit                hold_tog = 1'b0;
	bit                hold_seen = 1'b0;
	int                hold_left = 0;
	int                n_added = 0;
	logic [TIME_W-1:0] clock_ms = '0;

	stb_cmd_if cmd_bus ();
	stb_rsp_if rsp_bus ();

	soft_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	stb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_bus),
		.rsp         (rsp_bus),
		.mismatches  (err_cnt),
		.outstanding (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 500_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever the toggle flips.
	initial begin
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Entered just after a rising edge; returns at the edge that accepts the word.
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] per, input logic ntf, input logic [TIME_W-1:0] now);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= f;
		cmd_bus.timer_id <= id;
		cmd_bus.period <= per;
		cmd_bus.notify <= ntf;
		cmd_bus.now_ms <= now;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		if (f == FN_ADD && n_added < NUM_TIMERS)
			n_added++;
		if (f == FN_UPDATE)
			clock_ms = now;
	endtask

	// Drop valid and wait until every queued word has come back.
	task automatic drain();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		wait (in_flight == 0);
		@(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 60)
			return $urandom_range(300, 1);
		else if (r < 75)
			return $urandom_range(20, 1);
		else if (r < 85)
			return $urandom;
		else
			return 32'hFFFF_FFFF - $urandom_range(3);
	endfunction

	function automatic logic [TIME_W-1:0] pick_step();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 75)
			return $urandom_range(150, 1);
		else if (r < 85)
			return $urandom_range(5000);
		else if (r < 93)
			return $urandom;
		else
			return 32'hFFFF_FFFF - $urandom_range(50);
	endfunction

	task automatic random_cmd();
		int              r;
		logic [ID_W-1:0] bad;
		r = $urandom_range(99);
		if (r < 8) begin
			send_cmd(FN_ADD, ID_W'($urandom_range(31)), pick_period(),
				($urandom_range(3) != 0), $urandom);
		end else if (r < 53 || n_added == 0) begin
			send_cmd(FN_UPDATE, ID_W'($urandom_range(31)), $urandom, 1'($urandom_range(1)),
				clock_ms + pick_step());
		end else if (r < 70) begin
			send_cmd(FN_START, ID_W'($urandom_range(n_added, 1)), $urandom,
				1'($urandom_range(1)), $urandom);
		end else if (r < 80) begin
			send_cmd(FN_RESUME, ID_W'($urandom_range(n_added, 1)), $urandom,
				1'($urandom_range(1)), $urandom);
		end else if (r < 89) begin
			send_cmd(FN_PAUSE, ID_W'($urandom_range(n_added, 1)), $urandom,
				1'($urandom_range(1)), $urandom);
		end else if (r < 97) begin
			case ($urandom_range(2))
				0: bad = '0;
				1: bad = (n_added < NUM_TIMERS) ?
					ID_W'($urandom_range(NUM_TIMERS, n_added + 1)) : '0;
				default: bad = ID_W'($urandom_range(31, 17));
			endcase
			send_cmd(FUNC_W'(FN_START + $urandom_range(2)), bad, $urandom,
				1'($urandom_range(1)), $urandom);
		end else begin
			send_cmd(FUNC_W'(FN_SPARE_LO + $urandom_range(2)), ID_W'($urandom_range(31)),
				$urandom, 1'($urandom_range(1)), $urandom);
		end
	endtask

	initial begin
		cmd_bus.valid <= 1'b0;
		cmd_bus.func <= FN_ADD;
		cmd_bus.timer_id <= '0;
		cmd_bus.period <= '0;
		cmd_bus.notify <= 1'b0;
		cmd_bus.now_ms <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty bank, bad ids, period extremes, wrap and saturation.
		send_cmd(FN_UPDATE, 0, 0, 0, 32'd7);
		send_cmd(FN_START, 0, 0, 0, 0);
		send_cmd(FN_RESUME, 1, 0, 0, 0);
		send_cmd(FN_ADD, 0, 32'd0, 1'b1, 0);
		send_cmd(FN_ADD, 0, 32'hFFFF_FFFF, 1'b1, 0);
		send_cmd(FN_ADD, 0, 32'd10, 1'b0, 0);
		send_cmd(FN_ADD, 0, 32'd25, 1'b1, 0);
		for (int i = 1; i <= 4; i++)
			send_cmd(FN_START, ID_W'(i), 0, 0, 0);
		send_cmd(FN_UPDATE, 0, 0, 0, 32'd12);
		send_cmd(FN_UPDATE, 0, 0, 0, 32'hFFFF_FFF0);
		send_cmd(FN_UPDATE, 0, 0, 0, 32'h0000_0020);
		send_cmd(FN_PAUSE, 4, 0, 0, 0);
		send_cmd(FN_UPDATE, 0, 0, 0, 32'h0000_0030);
		send_cmd(FN_RESUME, 4, 0, 0, 0);
		send_cmd(FN_PAUSE, 16, 0, 0, 0);
		send_cmd(FN_RESUME, 31, 0, 0, 0);
		send_cmd(FN_SPARE_LO, 0, 0, 0, 0);
		send_cmd(FN_SPARE_HI, 31, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_cmd(FN_START, 4, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 48;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 48;
				end
				default: begin
					tx_idle_pct = 9;
					rx_stall_pct = 9;
				end
			endcase
			for (int k = 0; k < 90; k++) begin
				// stall the output for a long stretch while words keep coming, and drain once mid phase 1
				if (ph == 2 && k == 20)
					hold_tog = !hold_tog;
				if (ph == 1 && k == 45)
					drain();
				random_cmd();
			end
			drain();
		end

		rx_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && in_flight == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
